/* src/hufd_pkg.sv */
// Shared types and constants of the table-driven Huffman decoder.
`default_nettype none

package hufd_pkg;

  // Bits in one compressed byte; also the upper bound of the pad count.
  localparam int ByteBits = 8;

  // Table cells are scanned in groups of this size in the first select stage.
  localparam int CellGroup = 16;
  localparam int LocW      = $clog2(CellGroup);

  // Meaning of the mode field of an input item.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_COMPARE,
    ST_SELECT,
    ST_FETCH,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic        mode;
    logic [7:0]  entry_index;
    logic [7:0]  entry_symbol;
    logic [4:0]  entry_length;
    logic [15:0] entry_code;
    logic [7:0]  data_byte;
    logic        frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       run_last;
    logic       frame_end;
    logic       code_overflow;
  } out_item_t;

endpackage

`default_nettype wire

/* src/huffman_table_decoder.sv */
// Top level of the table-driven Huffman decoder: code table cells, bit-serial decode loop.
`default_nettype none

// The block decodes a bit stream against a code table that the user loads item by
// item. A load item (mode 0) writes one table entry and leaves the block idle; an
// index at or beyond TABLE_ENTRIES is ignored. Only entries below active_entries take
// part in matching, and the lowest-index match wins. The first data item of a frame
// carries the pad count (clamped to 8). Each later data item is taken MSB first, one
// code bit at a time, and every bit passes a shift step that moves it into the current
// code, a compare step in which every table cell compares its code in parallel and
// each group of sixteen cells picks its first hit, and a select step that picks the
// first group and starts the symbol memory read. A match adds a fetch step for the
// symbol read, a flush step ends the byte, and a stalled output can hold both. Results
// of one byte leave in order; the last of them carries run_last. The table is not
// cleared at reset: entries must be written before a frame that can reach them is
// decoded. active_entries is written through cfg_we_i / cfg_data_i; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module huffman_table_decoder #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_LEN  = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [8:0]          cfg_data_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  hufd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output hufd_pkg::out_item_t out_item_o
);
  import hufd_pkg::*;

  localparam int IdxW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NumGroups = (TABLE_ENTRIES + CellGroup - 1) / CellGroup;
  localparam int LenW      = $clog2(MAX_CODE_LEN + 1);
  localparam int CmpW      = (LenW > 5) ? LenW : 5;
  localparam int CodeW     = (MAX_CODE_LEN > 16) ? MAX_CODE_LEN : 16;

  // Control state.
  state_e            state_q, state_d;
  logic [8:0]        active_q;
  logic [MAX_CODE_LEN-1:0] partial_q;
  logic [LenW-1:0]   plen_q;
  logic [3:0]        pad_q;
  logic              await_q;
  logic              ovf_q;
  logic [3:0]        bits_left_q;
  logic              held_vld_q;
  logic              out_vld_q;

  // Payload registers.
  logic [7:0]        byte_q;
  logic              last_q;
  out_item_t         held_q;
  out_item_t         out_q;
  logic [7:0]        sym_rd_q;
  logic              grp_hit_q [NumGroups];
  logic [LocW-1:0]   grp_idx_q [NumGroups];
  logic              grp_hit_d [NumGroups];
  logic [LocW-1:0]   grp_idx_d [NumGroups];

  // Table: length and code live in one cell per entry, the symbol in a memory.
  logic [4:0]        cell_len_q  [TABLE_ENTRIES];
  logic [CodeW-1:0]  cell_code_q [TABLE_ENTRIES];
  logic [7:0]        sym_mem     [TABLE_ENTRIES];

  // Strobes from the control decode.
  logic accept;
  logic load_we;
  logic pad_take;
  logic byte_take;
  logic push_out;
  logic push_last;
  logic take_held;
  logic byte_done;
  logic out_free;

  logic [3:0]        nbits;
  logic [3:0]        pad_clamped;
  logic              write_ok;
  logic [CodeW-1:0]  mask;
  logic [CodeW-1:0]  partial_ext;
  logic [NumGroups*CellGroup-1:0] match;
  logic              sel_hit;
  logic [IdxW-1:0]   sel_idx;
  logic              at_max;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign nbits       = in_item_i.frame_last ? (4'(ByteBits) - pad_q) : 4'(ByteBits);
  assign pad_clamped = (in_item_i.data_byte > 8'(ByteBits)) ? 4'(ByteBits)
                                                             : in_item_i.data_byte[3:0];
  assign write_ok    = (9'(in_item_i.entry_index) < 9'(TABLE_ENTRIES));
  assign partial_ext = CodeW'(partial_q);
  assign at_max      = (plen_q >= LenW'(MAX_CODE_LEN));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_item_i.mode == MODE_DATA && !await_q) begin
          state_d = (nbits == 4'd0) ? ST_FLUSH : ST_SHIFT;
        end
      end
      ST_SHIFT:   state_d = ST_COMPARE;
      ST_COMPARE: state_d = ST_SELECT;
      ST_SELECT: begin
        if (sel_hit) begin
          state_d = ST_FETCH;
        end else begin
          state_d = (bits_left_q == 4'd0) ? ST_FLUSH : ST_SHIFT;
        end
      end
      ST_FETCH: begin
        if (!held_vld_q || out_free) begin
          state_d = (bits_left_q == 4'd0) ? ST_FLUSH : ST_SHIFT;
        end
      end
      ST_FLUSH: begin
        if (!held_vld_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs and strobes.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && (state_q == ST_IDLE);
    load_we    = accept && (in_item_i.mode == MODE_LOAD) && write_ok;
    pad_take   = accept && (in_item_i.mode == MODE_DATA) && await_q;
    byte_take  = accept && (in_item_i.mode == MODE_DATA) && !await_q;
    push_out   = 1'b0;
    push_last  = 1'b0;
    take_held  = 1'b0;
    byte_done  = 1'b0;
    case (state_q)
      ST_FETCH: begin
        take_held = !held_vld_q || out_free;
        push_out  = held_vld_q && out_free;
      end
      ST_FLUSH: begin
        byte_done = !held_vld_q || out_free;
        push_out  = held_vld_q && out_free;
        push_last = 1'b1;
      end
      default: begin
        push_out = 1'b0;
      end
    endcase
  end

  // Every cell compares its masked code with the current code.
  always_comb begin
    for (int k = 0; k < CodeW; k++) begin
      mask[k] = (CmpW'(k) < CmpW'(plen_q));
    end
  end

  always_comb begin
    match = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = (9'(i) < active_q)
              && (CmpW'(cell_len_q[i]) == CmpW'(plen_q))
              && ((cell_code_q[i] & mask) == partial_ext);
    end
  end

  // First select stage: lowest hit inside each group of cells.
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int l = CellGroup - 1; l >= 0; l--) begin
        if (match[g * CellGroup + l]) begin
          grp_hit_d[g] = 1'b1;
          grp_idx_d[g] = LocW'(l);
        end
      end
    end
  end

  // Second select stage: lowest group with a hit.
  always_comb begin
    sel_hit = 1'b0;
    sel_idx = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) begin
        sel_hit = 1'b1;
        sel_idx = IdxW'(g * CellGroup) + IdxW'(grp_idx_q[g]);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      partial_q   <= '0;
      plen_q      <= '0;
      pad_q       <= '0;
      await_q     <= 1'b1;
      ovf_q       <= 1'b0;
      bits_left_q <= '0;
      held_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
      if (pad_take) begin
        pad_q     <= pad_clamped;
        partial_q <= '0;
        plen_q    <= '0;
        ovf_q     <= 1'b0;
        await_q   <= in_item_i.frame_last;
      end
      if (byte_take) begin
        bits_left_q <= nbits;
      end
      if (state_q == ST_SHIFT) begin
        partial_q   <= MAX_CODE_LEN'({partial_q, byte_q[7]});
        plen_q      <= plen_q + LenW'(1);
        bits_left_q <= bits_left_q - 4'd1;
      end
      if (state_q == ST_SELECT) begin
        if (sel_hit) begin
          partial_q <= '0;
          plen_q    <= '0;
        end else if (at_max) begin
          // An unmatched code at full length is dropped and flagged.
          partial_q <= '0;
          plen_q    <= '0;
          ovf_q     <= 1'b1;
        end
      end
      if (take_held) begin
        held_vld_q <= 1'b1;
      end else if (byte_done) begin
        held_vld_q <= 1'b0;
      end
      if (byte_done && last_q) begin
        partial_q <= '0;
        plen_q    <= '0;
        await_q   <= 1'b1;
      end
      if (push_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (byte_take) begin
      byte_q <= in_item_i.data_byte;
      last_q <= in_item_i.frame_last;
    end
    if (state_q == ST_SHIFT) begin
      byte_q <= {byte_q[6:0], 1'b0};
    end
    if (state_q == ST_COMPARE) begin
      for (int g = 0; g < NumGroups; g++) begin
        grp_hit_q[g] <= grp_hit_d[g];
        grp_idx_q[g] <= grp_idx_d[g];
      end
    end
    if (take_held) begin
      held_q.symbol        <= sym_rd_q;
      held_q.run_last      <= 1'b0;
      held_q.frame_end     <= last_q;
      held_q.code_overflow <= ovf_q;
    end
    if (push_out) begin
      out_q <= {held_q.symbol, push_last, held_q.frame_end, held_q.code_overflow};
    end
    if (load_we) begin
      cell_len_q[in_item_i.entry_index[IdxW-1:0]]  <= in_item_i.entry_length;
      cell_code_q[in_item_i.entry_index[IdxW-1:0]] <= CodeW'(in_item_i.entry_code);
    end
  end

  // Symbol memory: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      sym_mem[in_item_i.entry_index[IdxW-1:0]] <= in_item_i.entry_symbol;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SELECT && sel_hit) begin
      sym_rd_q <= sym_mem[sel_idx];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* src/hufd_checker.sv */
// Port-level checks of the Huffman decoder and their binding to the top level.
`default_nettype none

module hufd_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input hufd_pkg::in_item_t  in_item_i,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input hufd_pkg::out_item_t out_item_o
);
  import hufd_pkg::*;

  // A result waiting on a stalled output stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // A stalled result does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("output item changed while stalled");

  // A table load finishes in the cycle it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.mode == MODE_LOAD |=> !in_stall_o)
    else $error("table load kept the input stalled");

  // A result that is not the last of its byte means the byte is still in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.run_last |-> in_stall_o)
    else $error("byte finished before its last result was issued");

endmodule

bind huffman_table_decoder hufd_checker u_hufd_checker (.*);

`default_nettype wire
